// File: design/ptl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_pkg: shared types and constants of the pedestrian traffic light
// Phase codes, register indexes, reset values and the state/config structs.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    PH_GREEN  = 3'd0,
    PH_YELLOW = 3'd1,
    PH_WALK   = 3'd2,
    PH_FLASH  = 3'd3,
    PH_NIGHT  = 3'd4
  } phase_e;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_GREEN_TICKS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_YELLOW_TICKS   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WALK_TICKS     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FLASH_TICKS    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DARK_THRESHOLD = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NIGHT_CONFIRM  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DAY_CONFIRM    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_BUTTON_CUT     = 3'd7;

  // Register reset values
  localparam logic [7:0]  RST_GREEN_TICKS    = 8'd12;
  localparam logic [7:0]  RST_YELLOW_TICKS   = 8'd6;
  localparam logic [7:0]  RST_WALK_TICKS     = 8'd12;
  localparam logic [7:0]  RST_FLASH_TICKS    = 8'd10;
  localparam logic [15:0] RST_DARK_THRESHOLD = 16'd53000;
  localparam logic [7:0]  RST_NIGHT_CONFIRM  = 8'd10;
  localparam logic [7:0]  RST_DAY_CONFIRM    = 8'd10;
  localparam logic [7:0]  RST_BUTTON_CUT     = 8'd10;

  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_BUTTON = 1'b1;

  typedef struct packed {
    logic [7:0]  green_ticks;
    logic [7:0]  yellow_ticks;
    logic [7:0]  walk_ticks;
    logic [7:0]  flash_ticks;
    logic [15:0] dark_threshold;
    logic [7:0]  night_confirm;
    logic [7:0]  day_confirm;
    logic [7:0]  button_cut;
  } ptl_cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] phase_count;
    logic [7:0] dark_count;
    logic [7:0] light_count;
    logic       ped_red;
    logic       yellow;
  } ptl_state_t;

endpackage
`default_nettype wire

// File: design/ptl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_in_if / ptl_out_if: request and result channels
// Valid/ready channels carrying tick or button requests and light results.
// ----------------------------------------------------------------------------
interface ptl_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] light_level;

  modport source (output valid, output mode, output light_level, input ready);
  modport sink   (input valid, input mode, input light_level, output ready);
endinterface

interface ptl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase;
  logic       ped_red_led;
  logic       yellow_led;

  modport source (output valid, output phase, output ped_red_led, output yellow_led,
                  input ready);
  modport sink   (input valid, input phase, input ped_red_led, input yellow_led,
                  output ready);
endinterface
`default_nettype wire

// File: design/ptl_next.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptl_next: next-state logic of the traffic light
// Applies one tick or button request to the current state.
// ----------------------------------------------------------------------------
module ptl_next (
  input  ptl_pkg::ptl_state_t state_i,
  input  ptl_pkg::ptl_cfg_t   cfg_i,
  input  logic                mode_i,
  input  logic [15:0]         light_level_i,
  output ptl_pkg::ptl_state_t state_o
);
  import ptl_pkg::*;

  // One counted phase: advance the count, toggle the pedestrian lamp in flash, move on when it matches.
  function automatic ptl_state_t run_phase(ptl_state_t s, phase_e here,
                                           logic [7:0] limit, phase_e nxt);
    ptl_state_t r;
    r = s;
    if (s.phase == here) begin
      r.phase_count = s.phase_count + 8'd1;
      if (here == PH_FLASH) begin
        r.ped_red = ~s.ped_red;
      end
      if (r.phase_count == limit) begin
        r.phase       = nxt;
        r.phase_count = 8'd0;
      end
    end
    return r;
  endfunction

  logic       dark;
  ptl_state_t s0, s1, s2, s3, s4, s5;

  assign dark = light_level_i > cfg_i.dark_threshold;

  // Phase rules in order, so yellow, walk and flash run in the same tick they are entered
  assign s0 = run_phase(state_i, PH_GREEN, cfg_i.green_ticks, PH_YELLOW);
  assign s1 = run_phase(s0, PH_YELLOW, cfg_i.yellow_ticks, PH_WALK);
  assign s2 = run_phase(s1, PH_WALK, cfg_i.walk_ticks, PH_FLASH);
  assign s3 = run_phase(s2, PH_FLASH, cfg_i.flash_ticks, PH_GREEN);

  // Night entry
  always_comb begin
    s4 = s3;
    if (s3.phase != PH_NIGHT) begin
      if (dark) begin
        s4.dark_count = s3.dark_count + 8'd1;
        if (s4.dark_count == cfg_i.night_confirm) begin
          s4.phase      = PH_NIGHT;
          s4.dark_count = 8'd0;
          s4.yellow     = 1'b0;
          s4.ped_red    = 1'b0;
        end
      end else begin
        s4.dark_count = 8'd0;
      end
    end
  end

  // Night mode: count consecutive light ticks, blink both lamps
  always_comb begin
    s5 = s4;
    if (s4.phase == PH_NIGHT) begin
      if (dark) begin
        s5.light_count = 8'd0;
      end else if (s4.light_count != 8'hFF) begin
        s5.light_count = s4.light_count + 8'd1;
      end
      if (s5.light_count >= cfg_i.day_confirm) begin
        s5.phase       = PH_GREEN;
        s5.light_count = 8'd0;
        s5.phase_count = 8'd0;
      end
      s5.ped_red = ~s4.ped_red;
      s5.yellow  = ~s4.yellow;
    end
  end

  // Button press cuts car green short
  always_comb begin
    state_o = state_i;
    if (mode_i == MODE_TICK) begin
      state_o = s5;
    end else if (state_i.phase == PH_GREEN && state_i.phase_count < cfg_i.button_cut) begin
      state_o.phase_count = cfg_i.button_cut;
    end
  end

endmodule
`default_nettype wire

// File: design/pedestrian_traffic_light_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pedestrian_traffic_light_fsm: car/pedestrian light controller with night mode
// Each request is a timer tick with a light sample or a pedestrian button press.
// Every request yields one result: the phase and the two blinking lamp levels.
//
// Use:
//   in_i   request channel (mode: 0 tick, 1 button; light_level on ticks).
//   out_o  result channel (phase 0 green .. 4 night, ped_red_led, yellow_led).
//   cfg_*  register write port; write only while no result is outstanding.
// The result is registered; a request's result shows in the cycle after its
// accept. Throughput is one request per cycle unless the sink stalls; the
// controller state updates on accept, so the next request sees it at once.
// The result register is the only buffer: while a result is held, a new
// request is taken in the same cycle the sink takes that result, and when
// the sink stalls, ready drops and the held result stays in place.
// Reset clears the state to car green with all counts and lamps at zero,
// empties the result register and loads the register reset values.
// ----------------------------------------------------------------------------
module pedestrian_traffic_light_fsm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ptl_in_if.sink                           in_i,
  ptl_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [ptl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ptl_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ptl_pkg::*;

  ptl_cfg_t   cfg_q;
  ptl_state_t state_q, state_d;
  logic       out_valid_q;
  logic [2:0] phase_q;
  logic       ped_red_q, yellow_q;
  logic       in_acc, out_acc;

  // Take a new request when the result slot is empty or being drained
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_acc    = out_valid_q & out_o.ready;

  // Configuration registers; unused upper data bits drop on 8-bit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_ticks    <= RST_GREEN_TICKS;
      cfg_q.yellow_ticks   <= RST_YELLOW_TICKS;
      cfg_q.walk_ticks     <= RST_WALK_TICKS;
      cfg_q.flash_ticks    <= RST_FLASH_TICKS;
      cfg_q.dark_threshold <= RST_DARK_THRESHOLD;
      cfg_q.night_confirm  <= RST_NIGHT_CONFIRM;
      cfg_q.day_confirm    <= RST_DAY_CONFIRM;
      cfg_q.button_cut     <= RST_BUTTON_CUT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GREEN_TICKS:    cfg_q.green_ticks    <= cfg_data_i[7:0];
        CFG_YELLOW_TICKS:   cfg_q.yellow_ticks   <= cfg_data_i[7:0];
        CFG_WALK_TICKS:     cfg_q.walk_ticks     <= cfg_data_i[7:0];
        CFG_FLASH_TICKS:    cfg_q.flash_ticks    <= cfg_data_i[7:0];
        CFG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data_i[15:0];
        CFG_NIGHT_CONFIRM:  cfg_q.night_confirm  <= cfg_data_i[7:0];
        CFG_DAY_CONFIRM:    cfg_q.day_confirm    <= cfg_data_i[7:0];
        CFG_BUTTON_CUT:     cfg_q.button_cut     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Next state for the request on the input channel
  ptl_next u_next (
    .state_i       (state_q),
    .cfg_i         (cfg_q),
    .mode_i        (in_i.mode),
    .light_level_i (in_i.light_level),
    .state_o       (state_d)
  );

  // Controller state advances only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_GREEN;
      state_q.phase_count <= 8'd0;
      state_q.dark_count  <= 8'd0;
      state_q.light_count <= 8'd0;
      state_q.ped_red     <= 1'b0;
      state_q.yellow      <= 1'b0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Result register: fill on accept, drop when the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      phase_q   <= state_d.phase;
      ped_red_q <= state_d.ped_red;
      yellow_q  <= state_d.yellow;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.phase       = phase_q;
  assign out_o.ped_red_led = ped_red_q;
  assign out_o.yellow_led  = yellow_q;

  // An accepted request always leaves a result waiting
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted request left no result");

  // State holds between requests
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(state_q))
    else $error("state changed without a request");

  // Leaving night always returns to car green
  a_night_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_NIGHT && in_acc && state_d.phase != PH_NIGHT)
      |-> state_d.phase == PH_GREEN)
    else $error("night left to a phase other than car green");

  // Light ticks are counted only in night, dark ticks only outside it
  a_count_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != PH_NIGHT |-> state_q.light_count == 8'd0) and
    (state_q.phase == PH_NIGHT |-> state_q.dark_count == 8'd0))
    else $error("day/night counter live in the wrong mode");

endmodule
`default_nettype wire
